@@ hw/rtl/cle_pkg.sv @@
// ----------------------------------------------------------------------------
// cle_pkg
// Shared constants, types and helpers of the console line editor.
// ----------------------------------------------------------------------------
`default_nettype none

package cle_pkg;

  // Line store geometry
  localparam int LINE_STORE_DEPTH = 256;
  localparam int ADDR_W           = $clog2(LINE_STORE_DEPTH);
  localparam int CNT_W            = $clog2(LINE_STORE_DEPTH + 1);

  // Stream payload widths
  localparam int IN_W  = 8;
  localparam int OUT_W = 40;

  // Character codes
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // Command words, first character in element 0
  localparam logic [3:0][7:0] WORD_EXIT = {8'h54, 8'h49, 8'h58, 8'h45};
  localparam logic [3:0][7:0] WORD_QUIT = {8'h54, 8'h49, 8'h55, 8'h51};

  localparam logic [7:0] MAX_LEN_RESET = 8'd255;

  // Control from the sequencer to the word matcher
  typedef struct packed {
    logic clear;  // restart the match for a new line
    logic valid;  // read data from the line store is present
  } scan_ctl_t;

  // Effective line limit: zero acts as one, capped at the store depth
  function automatic logic [CNT_W-1:0] eff_max(input logic [7:0] m);
    logic [CNT_W-1:0] v;
    v = CNT_W'(m);
    if (m == 8'd0) v = CNT_W'(1);
    if (v > CNT_W'(LINE_STORE_DEPTH)) v = CNT_W'(LINE_STORE_DEPTH);
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cle_line_ram.sv @@
// ----------------------------------------------------------------------------
// cle_line_ram
// Line store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_line_ram (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [cle_pkg::ADDR_W-1:0] waddr,
  input  wire logic [7:0]                wdata,
  input  wire logic                      re,
  input  wire logic [cle_pkg::ADDR_W-1:0] raddr,
  output logic      [7:0]                rdata
);
  import cle_pkg::*;

  logic [7:0] mem [LINE_STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/cle_word_match.sv @@
// ----------------------------------------------------------------------------
// cle_word_match
// Walks the stored line one character per cycle, trims blanks at both ends,
// folds case and checks the trimmed text against the exit words.
// ----------------------------------------------------------------------------
`default_nettype none

module cle_word_match (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cle_pkg::scan_ctl_t ctl,
  input  wire logic [7:0]         data,
  output logic                    match
);
  import cle_pkg::*;

  localparam logic [2:0] POS_SAT = 3'd5;

  logic             started;  // first non-blank seen
  logic [2:0]       pos;      // characters since the first non-blank, saturating
  logic [2:0]       len;      // trimmed length, saturating
  logic [3:0][7:0]  word;     // first four characters of the trimmed text

  logic       blank;
  logic [7:0] upper;
  logic [2:0] pos_next;

  always_comb begin
    blank    = (data == CH_SP) || (data == CH_TAB);
    upper    = ((data >= CH_LO_A) && (data <= CH_LO_Z)) ? (data - CASE_OFS) : data;
    pos_next = (pos == POS_SAT) ? POS_SAT : (pos + 3'd1);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      started <= 1'b0;
      pos     <= 3'd0;
      len     <= 3'd0;
    end else if (ctl.valid && (started || !blank)) begin
      started <= 1'b1;
      pos     <= pos_next;
      if (!blank) begin
        len <= pos_next;
      end
    end
    if (!rst && !ctl.clear && ctl.valid && (started || !blank) && (pos < 3'd4)) begin
      word[pos[1:0]] <= upper;
    end
  end

  assign match = (len == 3'd4) && ((word == WORD_EXIT) || (word == WORD_QUIT));

endmodule

`default_nettype wire

@@ hw/rtl/console_line_editor.sv @@
// ----------------------------------------------------------------------------
// console_line_editor
// Console line editor: builds an edited line from received characters and
// reports echoes, store writes and line completion as a result stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_tvalid/s_tready/s_tdata (character) with
//   s_tuser flagging end of input. Each request yields zero to four result
//   requests on m_tvalid/m_tready/m_tdata; m_tlast marks the final result of
//   a request. The user writes the line limit (zero acts as one) through
//   cfg_wr_en/cfg_wr_data only while the block is idle; the block does not check.
// Timing:
//   s_tready is high only while the sequencer is idle. An accepted request
//   emits its results one at a time in the emit step, which waits while a
//   result is still held in the output register. CR or LF on a non-empty
//   line first walks the stored line through the single read port of the
//   line store, one character per cycle, before the emit step starts.
//   The first result is loaded into the output register as soon as that
//   register is free or its result is being taken. The final result is
//   parked in the output register, so the next request is accepted while
//   it waits.
// Reset and stall:
//   rst (synchronous) empties the line, sets the limit to 255 and drops any
//   pending result. The store contents are not cleared. When the receiver
//   holds m_tready low, the emit step holds its place and the result stays.
// ----------------------------------------------------------------------------
`default_nettype none

module console_line_editor (
  input  wire logic                     clk,
  input  wire logic                     rst,
  // Line limit register
  input  wire logic                     cfg_wr_en,
  input  wire logic [7:0]               cfg_wr_data,
  // Input requests
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [cle_pkg::IN_W-1:0] s_tdata,   // [7:0] char_code
  input  wire logic                     s_tuser,   // [0] end_of_input
  // Result requests
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [cle_pkg::OUT_W-1:0]     m_tdata,   // [0] echo_valid, [8:1] echo_byte,
                                                   // [9] store_valid, [17:10] store_index,
                                                   // [25:18] store_byte, [26] line_done,
                                                   // [34:27] line_count, [35] halt_request,
                                                   // [39:36] zero
  output logic                          m_tlast
);
  import cle_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    K_EOF,
    K_NEWLINE,
    K_ERASE,
    K_CANCEL,
    K_STORE
  } kind_t;

  state_t           state;
  kind_t            kind;
  logic [1:0]       emit_k;
  logic [7:0]       ch;
  logic [CNT_W-1:0] line_len;    // finished line length, or store index
  logic [CNT_W-1:0] char_count;
  logic [7:0]       max_len;
  logic [CNT_W-1:0] scan_idx;
  logic             rd_vld;

  // Request decode
  logic             accept;
  logic [7:0]       in_ch;
  logic             is_nl, is_erase, is_cancel, can_store;
  logic [CNT_W-1:0] limit;
  logic [CNT_W-1:0] cfg_limit;

  // Line store and matcher
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  scan_ctl_t        scan_ctl;
  logic             match;
  logic             scan_last;

  // Result being emitted
  logic             r_echo_v, r_store_v, r_done, r_halt, r_last;
  logic [7:0]       r_echo_b;
  logic [OUT_W-1:0] r_data;

  always_comb begin
    accept    = s_tvalid && s_tready;
    in_ch     = s_tdata[7:0];
    is_nl     = (in_ch == CH_CR) || (in_ch == CH_LF);
    is_erase  = (in_ch == CH_BS) || (in_ch == CH_DEL);
    is_cancel = (in_ch == CH_CTRLC);
    limit     = eff_max(max_len);
    cfg_limit = eff_max(cfg_wr_data);
    can_store = !s_tuser && !is_nl && !is_erase && !is_cancel && (char_count < limit);
    ram_we    = accept && can_store;
    ram_re    = (state == S_SCAN);
    scan_last = (scan_idx == (line_len - CNT_W'(1)));
  end

  assign s_tready       = (state == S_IDLE);
  assign scan_ctl.clear = accept;
  assign scan_ctl.valid = rd_vld;

  cle_line_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (char_count[ADDR_W-1:0]),
    .wdata (in_ch),
    .re    (ram_re),
    .raddr (scan_idx[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  cle_word_match u_match (
    .clk   (clk),
    .rst   (rst),
    .ctl   (scan_ctl),
    .data  (ram_rdata),
    .match (match)
  );

  // Build result number emit_k of the current request
  always_comb begin
    r_echo_v  = 1'b0;
    r_echo_b  = 8'd0;
    r_store_v = 1'b0;
    r_done    = 1'b0;
    r_halt    = 1'b0;
    r_last    = 1'b0;
    case (kind)
      K_EOF: begin
        r_done = 1'b1;
        r_halt = 1'b1;
        r_last = 1'b1;
      end
      K_NEWLINE: begin
        r_echo_v = 1'b1;
        r_echo_b = (emit_k == 2'd0) ? CH_CR : CH_LF;
        r_done   = (emit_k == 2'd1);
        r_halt   = (emit_k == 2'd1) && match;
        r_last   = (emit_k == 2'd1);
      end
      K_ERASE: begin
        r_echo_v = 1'b1;
        r_echo_b = (emit_k == 2'd1) ? CH_SP : CH_BS;
        r_last   = (emit_k == 2'd2);
      end
      K_CANCEL: begin
        r_echo_v = 1'b1;
        case (emit_k)
          2'd0:    r_echo_b = CH_CARET;
          2'd1:    r_echo_b = CH_C;
          2'd2:    r_echo_b = CH_CR;
          default: r_echo_b = CH_LF;
        endcase
        r_done = (emit_k == 2'd3);
        r_last = (emit_k == 2'd3);
      end
      K_STORE: begin
        r_echo_v  = 1'b1;
        r_echo_b  = ch;
        r_store_v = 1'b1;
        r_last    = 1'b1;
      end
      default: begin
        r_last = 1'b1;
      end
    endcase
    r_data = {4'd0,
              r_halt,
              r_done ? 8'(line_len) : 8'd0,
              r_done,
              r_store_v ? ch : 8'd0,
              r_store_v ? 8'(line_len) : 8'd0,
              r_store_v,
              r_echo_b,
              r_echo_v};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      kind       <= K_EOF;
      emit_k     <= 2'd0;
      char_count <= '0;
      max_len    <= MAX_LEN_RESET;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tlast    <= 1'b0;
    end else begin
      rd_vld <= ram_re;

      // Drop a result once the receiver takes it, unless the emit step
      // loads the next one at the same edge
      if (m_tvalid && m_tready && (state != S_EMIT)) begin
        m_tvalid <= 1'b0;
      end

      // Limit write: cut the current line down to the new limit
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
        if (char_count > cfg_limit) begin
          char_count <= cfg_limit;
        end
      end

      case (state)
        S_IDLE: begin
          emit_k   <= 2'd0;
          scan_idx <= '0;
          if (accept) begin
            ch <= in_ch;
            if (s_tuser) begin
              kind       <= K_EOF;
              line_len   <= char_count;
              char_count <= '0;
              state      <= S_EMIT;
            end else if (is_nl) begin
              kind       <= K_NEWLINE;
              line_len   <= char_count;
              char_count <= '0;
              state      <= (char_count == '0) ? S_EMIT : S_SCAN;
            end else if (is_erase) begin
              if (char_count != '0) begin
                kind       <= K_ERASE;
                char_count <= char_count - CNT_W'(1);
                state      <= S_EMIT;
              end
            end else if (is_cancel) begin
              kind       <= K_CANCEL;
              line_len   <= '0;
              char_count <= '0;
              state      <= S_EMIT;
            end else if (can_store) begin
              kind       <= K_STORE;
              line_len   <= char_count;
              char_count <= char_count + CNT_W'(1);
              state      <= S_EMIT;
            end
          end
        end
        S_SCAN: begin
          // Advance the read address through the line
          scan_idx <= scan_idx + CNT_W'(1);
          if (scan_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          // Hold while the last character reaches the matcher
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= r_data;
            m_tlast  <= r_last;
            if (r_last) begin
              state <= S_IDLE;
            end else begin
              emit_k <= emit_k + 2'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
